FILE: src/sls_pkg.sv
// shared types and codes for the sorted list store
package sls_pkg;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_DEL_MIN = 3'd1,
    OP_DEL_MAX = 3'd2,
    OP_DEL_KEY = 3'd3,
    OP_DISPLAY = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT_LEFT,
    CELL_DEL_MATCH,
    CELL_ROTATE
  } cell_op_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_DISPLAY
  } fsm_state_t;

  typedef struct packed {
    cell_op_t op;
    logic     below_count;
    logic     at_count;
    logic     at_tail;
  } cell_ctl_t;

  localparam int OPCODE_W = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

endpackage

FILE: src/sorted_list_store_core.sv
// top level of the sorted list store: cell chain, control fsm and output register
// latency: insert and deletes give their result in the cycle after the input transfer
// throughput: one insert or delete per cycle while out_tready stays high
// display emits one entry per cycle while out_tready is high and takes no input meanwhile
// reset (rst_n low, synchronous) empties the store and drops any pending result;
// the entry cells themselves are not cleared, only the count that marks them valid
module sorted_list_store_core
  import sls_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  // input transfer
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // opcode [2:0], key_value [VALUE_WIDTH+2:3], zero fill above
  input  logic [((OPCODE_W+VALUE_WIDTH+7)/8)*8-1:0] in_tdata,
  // result transfer
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // status [1:0], result_value [VALUE_WIDTH+1:2], entry_count next 5 bits, zero fill above
  output logic [((STATUS_W+VALUE_WIDTH+COUNT_W+7)/8)*8-1:0] out_tdata,
  // last_of_run
  output logic                                      out_tlast
);

  localparam int CW    = $clog2(CAPACITY + 1);

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  fsm_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] disp_idx_r, disp_idx_nxt;

  // output register, parts the result side from the input side
  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [VALUE_WIDTH-1:0] out_value_r, out_value_nxt;
  logic                   out_last_r, out_last_nxt;
  logic [COUNT_W-1:0]     out_count_r, out_count_nxt;

  // ---------------------------------------------------------------------------
  // input decode
  // ---------------------------------------------------------------------------
  opcode_t                       in_opcode;
  logic signed [VALUE_WIDTH-1:0] in_key;
  logic                          in_xfer;
  logic                          slot_free;

  assign in_opcode = opcode_t'(in_tdata[OPCODE_W-1:0]);
  assign in_key    = $signed(in_tdata[OPCODE_W +: VALUE_WIDTH]);
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == FSM_IDLE) && slot_free;
  assign in_xfer   = in_tvalid && in_tready;

  // ---------------------------------------------------------------------------
  // cell chain
  // ---------------------------------------------------------------------------
  cell_op_t                      cell_op;
  cell_ctl_t                     cell_ctl   [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] cell_val   [CAPACITY];
  logic                          cell_move  [CAPACITY];
  logic                          cell_match [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] left_val   [CAPACITY];
  logic                          left_move  [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] right_val  [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] head_val;

  assign head_val = cell_val[0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    // position flags relative to the fill level
    assign cell_ctl[i] = '{op:          cell_op,
                           below_count: (CW'(i) < count_r),
                           at_count:    (count_r == CW'(i)),
                           at_tail:     (count_r == CW'(i + 1))};

    if (i == 0) begin : g_first
      assign left_val[i]  = '0;
      assign left_move[i] = 1'b0;
    end else begin : g_mid
      assign left_val[i]  = cell_val[i-1];
      assign left_move[i] = cell_move[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val[i] = '0;
    end else begin : g_inner
      assign right_val[i] = cell_val[i+1];
    end

    sls_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk         (clk),
      .ctl_i       (cell_ctl[i]),
      .key_i       (in_key),
      .head_i      (head_val),
      .left_val_i  (left_val[i]),
      .left_move_i (left_move[i]),
      .right_val_i (right_val[i]),
      .val_o       (cell_val[i]),
      .move_o      (cell_move[i]),
      .match_o     (cell_match[i])
    );
  end

  // largest entry and key hit, gathered across the chain
  logic signed [VALUE_WIDTH-1:0] tail_val;
  logic                          key_found;

  always_comb begin
    tail_val  = '0;
    key_found = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_ctl[i].at_tail) begin
        tail_val = tail_val | cell_val[i];
      end
      key_found = key_found | cell_match[i];
    end
  end

  // ---------------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------------
  logic          store_full;
  logic          store_empty;
  logic          disp_last;
  logic [CW-1:0] disp_idx_inc;
  logic [CW+COUNT_W-1:0] count_ext;

  assign store_full   = (count_r == CW'(CAPACITY));
  assign store_empty  = (count_r == '0);
  assign disp_idx_inc = disp_idx_r + CW'(1);
  assign disp_last    = (disp_idx_inc == count_r);
  assign count_ext    = {{COUNT_W{1'b0}}, count_nxt};

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    disp_idx_nxt   = disp_idx_r;
    cell_op        = CELL_HOLD;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    out_count_nxt  = out_count_r;

    case (state_r)
      FSM_IDLE: begin
        if (in_xfer) begin
          // every defined opcode leaves one result unless it starts a display
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          out_value_nxt  = '0;
          out_status_nxt = ST_OK;
          case (in_opcode)
            OP_INSERT: begin
              if (store_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                cell_op   = CELL_INSERT;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_DEL_MIN: begin
              if (store_empty) begin
                out_status_nxt = ST_UNDERFLOW;
              end else begin
                cell_op       = CELL_SHIFT_LEFT;
                out_value_nxt = head_val;
                count_nxt     = count_r - CW'(1);
              end
            end
            OP_DEL_MAX: begin
              if (store_empty) begin
                out_status_nxt = ST_UNDERFLOW;
              end else begin
                out_value_nxt = tail_val;
                count_nxt     = count_r - CW'(1);
              end
            end
            OP_DEL_KEY: begin
              if (store_empty) begin
                out_status_nxt = ST_UNDERFLOW;
              end else if (key_found) begin
                cell_op       = CELL_DEL_MATCH;
                out_value_nxt = in_key;
                count_nxt     = count_r - CW'(1);
              end else begin
                out_status_nxt = ST_NOT_FOUND;
              end
            end
            OP_DISPLAY: begin
              if (store_empty) begin
                out_status_nxt = ST_UNDERFLOW;
              end else begin
                out_valid_nxt = 1'b0;
                disp_idx_nxt  = '0;
                state_nxt     = FSM_DISPLAY;
              end
            end
            default: begin
              // undefined opcodes are dropped without a result
              out_valid_nxt = 1'b0;
            end
          endcase
          out_count_nxt = count_ext[COUNT_W-1:0];
        end
      end
      FSM_DISPLAY: begin
        // head of the chain goes out, the chain rotates it to the tail
        if (slot_free) begin
          cell_op        = CELL_ROTATE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_value_nxt  = head_val;
          out_last_nxt   = disp_last;
          out_count_nxt  = count_ext[COUNT_W-1:0];
          disp_idx_nxt   = disp_idx_inc;
          if (disp_last) begin
            state_nxt = FSM_IDLE;
          end
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      disp_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      disp_idx_r  <= disp_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
    out_count_r  <= out_count_nxt;
  end

  // ---------------------------------------------------------------------------
  // result port
  // ---------------------------------------------------------------------------
  always_comb begin
    out_tdata                                   = '0;
    out_tdata[STATUS_W-1:0]                     = out_status_r;
    out_tdata[STATUS_W +: VALUE_WIDTH]          = out_value_r;
    out_tdata[STATUS_W+VALUE_WIDTH +: COUNT_W]  = out_count_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // fill level never passes the number of cells
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // a display walk stays inside the stored entries
  a_disp_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_DISPLAY) |-> (disp_idx_r < count_r))
    else $error("display index past stored entries");

  // an accepted insert into a store with room grows it by exactly one
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_opcode == OP_INSERT) && !store_full)
      |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not grow the store");

  // display never changes the fill level
  a_disp_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_DISPLAY) |=> $stable(count_r))
    else $error("entry count changed during display");
`endif

endmodule

FILE: src/sls_cell.sv
// one storage cell of the sorted chain: holds one entry and shifts with its neighbors
module sls_cell
  import sls_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  cell_ctl_t                     ctl_i,
  input  logic signed [VALUE_WIDTH-1:0] key_i,
  input  logic signed [VALUE_WIDTH-1:0] head_i,
  input  logic signed [VALUE_WIDTH-1:0] left_val_i,
  input  logic                          left_move_i,
  input  logic signed [VALUE_WIDTH-1:0] right_val_i,
  output logic signed [VALUE_WIDTH-1:0] val_o,
  output logic                          move_o,
  output logic                          match_o
);

  logic signed [VALUE_WIDTH-1:0] val_r;
  logic signed [VALUE_WIDTH-1:0] val_nxt;
  logic                          key_lt;

  always_comb begin
    key_lt  = key_i < val_r;
    move_o  = ctl_i.below_count && key_lt;
    match_o = ctl_i.below_count && (val_r == key_i);
    val_o   = val_r;
    val_nxt = val_r;
    case (ctl_i.op)
      CELL_INSERT: begin
        // entries above the key move up one place, key lands in the gap
        if (left_move_i) begin
          val_nxt = left_val_i;
        end else if (move_o || ctl_i.at_count) begin
          val_nxt = key_i;
        end
      end
      CELL_SHIFT_LEFT: begin
        val_nxt = right_val_i;
      end
      CELL_DEL_MATCH: begin
        // sorted, so every entry from the first match on is not below the key
        if (key_lt || (val_r == key_i)) begin
          val_nxt = right_val_i;
        end
      end
      CELL_ROTATE: begin
        if (ctl_i.at_tail) begin
          val_nxt = head_i;
        end else if (ctl_i.below_count) begin
          val_nxt = right_val_i;
        end
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

FILE: tb/sv/sorted_list_shadow.sv
`timescale 1ns / 1ps
// shadow model of the sorted list store that predicts and checks each result transfer
module sorted_list_shadow
  import sls_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32,
  parameter int IN_W        = 40,
  parameter int OUT_W       = 40
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  input  logic             out_tlast,
  output int               mismatch_count,
  output int               results_owed
);

  typedef struct {
    status_t                status;
    logic [VALUE_WIDTH-1:0] value;
    logic                   last;
    logic [COUNT_W-1:0]     count;
  } list_result_t;

  logic signed [VALUE_WIDTH-1:0] shadow_list [CAPACITY];
  int                            shadow_count;
  list_result_t                  owed_results [$];
  list_result_t                  got, want;

  initial begin
    mismatch_count = 0;
    results_owed   = 0;
    shadow_count   = 0;
  end

  function automatic void owe_result(status_t st, logic [VALUE_WIDTH-1:0] v, logic last);
    list_result_t r;
    r.status = st;
    r.value  = v;
    r.last   = last;
    r.count  = COUNT_W'(shadow_count);
    owed_results.push_back(r);
  endfunction

  // close the gap at pos by moving later entries down one
  function automatic logic [VALUE_WIDTH-1:0] take_entry(int pos);
    logic [VALUE_WIDTH-1:0] v;
    v = shadow_list[pos];
    for (int i = pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
    shadow_count--;
    return v;
  endfunction

  function automatic void apply_list_op(logic [OPCODE_W-1:0] op,
                                        logic signed [VALUE_WIDTH-1:0] key);
    int pos;
    int hit;
    case (op)
      OP_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          owe_result(ST_FULL, '0, 1'b1);
        end else begin
          // new key lands after every equal entry
          pos = shadow_count;
          while (pos > 0 && key < shadow_list[pos-1]) begin
            shadow_list[pos] = shadow_list[pos-1];
            pos--;
          end
          shadow_list[pos] = key;
          shadow_count++;
          owe_result(ST_OK, '0, 1'b1);
        end
      end
      OP_DEL_MIN, OP_DEL_MAX: begin
        if (shadow_count == 0) begin
          owe_result(ST_UNDERFLOW, '0, 1'b1);
        end else begin
          pos = (op == OP_DEL_MIN) ? 0 : shadow_count - 1;
          owe_result(ST_OK, take_entry(pos), 1'b1);
        end
      end
      OP_DEL_KEY: begin
        if (shadow_count == 0) begin
          owe_result(ST_UNDERFLOW, '0, 1'b1);
        end else begin
          hit = -1;
          for (int i = 0; i < shadow_count; i++)
            if (hit < 0 && shadow_list[i] == key) hit = i;
          if (hit < 0) owe_result(ST_NOT_FOUND, '0, 1'b1);
          else         owe_result(ST_OK, take_entry(hit), 1'b1);
        end
      end
      OP_DISPLAY: begin
        if (shadow_count == 0) begin
          owe_result(ST_UNDERFLOW, '0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_count; i++)
            owe_result(ST_OK, shadow_list[i], i == shadow_count - 1);
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_count = 0;
      owed_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = status_t'(out_tdata[STATUS_W-1:0]);
        got.value  = out_tdata[STATUS_W+VALUE_WIDTH-1:STATUS_W];
        got.count  = out_tdata[STATUS_W+VALUE_WIDTH+COUNT_W-1:STATUS_W+VALUE_WIDTH];
        got.last   = out_tlast;
        if (owed_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result status %0d value %0h last %0b count %0d",
                     $realtime, got.status, got.value, got.last, got.count);
        end else begin
          want = owed_results.pop_front();
          if (got.status !== want.status || got.value !== want.value ||
              got.last !== want.last || got.count !== want.count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: result mismatch exp st %0d val %0h last %0b cnt %0d, got st %0d val %0h last %0b cnt %0d",
                       $realtime, want.status, want.value, want.last, want.count,
                       got.status, got.value, got.last, got.count);
          end
        end
      end
      if (in_tvalid && in_tready)
        apply_list_op(in_tdata[OPCODE_W-1:0], in_tdata[OPCODE_W+VALUE_WIDTH-1:OPCODE_W]);
    end
    results_owed = owed_results.size();
  end

endmodule

FILE: tb/sv/sorted_list_store_core_tb.sv
`timescale 1ns / 1ps
// top of the sorted list store testbench: clock, reset, stimulus, back pressure and verdict
module sorted_list_store_core_tb;
  import sls_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int IN_W        = ((OPCODE_W + VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_W       = ((STATUS_W + VALUE_WIDTH + COUNT_W + 7) / 8) * 8;
  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 19;

  // opcodes the block ignores
  localparam logic [OPCODE_W-1:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_LAST_UNUSED  = 3'd7;

  // traffic mix of a random phase, anything else is mixed traffic
  localparam int MIX_FILL  = 0;
  localparam int MIX_DRAIN = 1;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;

  int mismatch_count;
  int results_owed;
  int quiet_cycles;

  // knobs shared between the sender and receiver processes
  bit tx_steady;
  bit rx_steady;
  bit hold_req;
  bit hold_done;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  sorted_list_store_core #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  sorted_list_shadow #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH),
    .IN_W       (IN_W),
    .OUT_W      (OUT_W)
  ) shadow (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed)
  );

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // small pool gives duplicates and delete hits, extremes and full-width noise for the rest
  function automatic logic [VALUE_WIDTH-1:0] rand_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return VALUE_WIDTH'(int'($urandom_range(0, 8)) - 4);
    if (r < 65) begin
      case ($urandom_range(0, 3))
        0:       return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        1:       return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
        2:       return '0;
        default: return '1;
      endcase
    end
    return VALUE_WIDTH'($urandom());
  endfunction

  function automatic logic [OPCODE_W-1:0] pick_op(int mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 75) return OP_INSERT;
        if (r < 80) return OP_DISPLAY;
        if (r < 87) return OP_DEL_MIN;
        if (r < 93) return OP_DEL_MAX;
        return OP_DEL_KEY;
      end
      MIX_DRAIN: begin
        if (r < 15) return OP_INSERT;
        if (r < 30) return OP_DEL_MIN;
        if (r < 45) return OP_DEL_MAX;
        if (r < 88) return OP_DEL_KEY;
        return OP_DISPLAY;
      end
      default: begin
        if (r < 35) return OP_INSERT;
        if (r < 50) return OP_DEL_MIN;
        if (r < 60) return OP_DEL_MAX;
        if (r < 82) return OP_DEL_KEY;
        return OP_DISPLAY;
      end
    endcase
  endfunction

  // offer one item at the falling edge and hold it until the transfer, then maybe idle
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [VALUE_WIDTH-1:0] key);
    logic [IN_W-1:0] word;
    int              gap;
    word = '0;
    word[OPCODE_W-1:0] = op;
    word[OPCODE_W+VALUE_WIDTH-1:OPCODE_W] = key;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = tx_steady ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // receiver: random stalls, plus one long hold so the block backs up into its input
  initial begin
    int n;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        n = rx_steady ? 0 : idle_len();
        if (n == 0) begin
          out_tready <= 1'b1;
          repeat ($urandom_range(0, 7)) @(negedge clk);
        end else begin
          out_tready <= 1'b0;
          repeat (n - 1) @(negedge clk);
        end
      end
    end
  end

  // watchdog: any transfer on either side resets the quiet count
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int mix;
    int sent;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    hold_req  = 1'b0;
    hold_done = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every delete and display on an empty store reports underflow
    send_item(OP_DISPLAY, '0);
    send_item(OP_DEL_MIN, '0);
    send_item(OP_DEL_MAX, '0);
    send_item(OP_DEL_KEY, '0);
    // extremes of the key range, a duplicate pair to check ordering among equals
    send_item(OP_INSERT, {1'b0, {(VALUE_WIDTH-1){1'b1}}});
    send_item(OP_INSERT, {1'b1, {(VALUE_WIDTH-1){1'b0}}});
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, '1);
    send_item(OP_INSERT, VALUE_WIDTH'(1));
    send_item(OP_INSERT, VALUE_WIDTH'(5));
    send_item(OP_INSERT, VALUE_WIDTH'(5));
    send_item(OP_DISPLAY, '0);
    // key miss, then a hit on the duplicate
    send_item(OP_DEL_KEY, VALUE_WIDTH'(12345));
    send_item(OP_DEL_KEY, VALUE_WIDTH'(5));
    send_item(OP_DEL_MIN, '0);
    send_item(OP_DEL_MAX, '0);
    // unused opcodes give no result
    send_item(OP_FIRST_UNUSED, rand_key());
    send_item(OP_FIRST_UNUSED + 3'd1, rand_key());
    send_item(OP_LAST_UNUSED, VALUE_WIDTH'($urandom()));
    // most negative value is gone by now
    send_item(OP_DEL_KEY, {1'b1, {(VALUE_WIDTH-1){1'b0}}});
    send_item(OP_DISPLAY, '0);

    // random phases cycle through fill, drain and mixed traffic
    for (int phase = 0; phase < PHASES; phase++) begin
      mix       = phase % 3;
      tx_steady = (phase == 0) || ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      // long receiver hold while the sender keeps offering fill traffic
      if (phase == 0) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 3) begin
          send_item(OP_LAST_UNUSED - 3'($urandom_range(0, 2)), rand_key());
        end else begin
          send_item(pick_op(mix), rand_key());
          sent++;
        end
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    // room for a display burst that should not be there
    repeat (40) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
